### src/oas_pkg.sv
// shared types, codes and constants for the obstacle avoidance sequencer
package oas_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CMP_BITS   = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [15:0] DIST_RESET = 16'd9999;
    localparam logic [3:0]  LINE_NONE  = 4'hF;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_DISTANCE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WARN_DISTANCE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_HOLD     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAP           = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SEARCH_TMO    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PING_PERIOD   = 3'd5;

    // drive commands
    localparam logic [2:0] DRIVE_HOLD    = 3'd0;
    localparam logic [2:0] DRIVE_STOP    = 3'd1;
    localparam logic [2:0] DRIVE_SLOW    = 3'd2;
    localparam logic [2:0] DRIVE_BASE    = 3'd3;
    localparam logic [2:0] DRIVE_FORWARD = 3'd4;
    localparam logic [2:0] DRIVE_ROTATE  = 3'd5;

    // overtake start codes
    localparam logic [1:0] START_NONE  = 2'd0;
    localparam logic [1:0] START_PASS1 = 2'd1;
    localparam logic [1:0] START_PASS2 = 2'd2;

    // external mode codes
    localparam logic [2:0] CODE_FOLLOW = 3'd0;
    localparam logic [2:0] CODE_STOP   = 3'd1;
    localparam logic [2:0] CODE_PASS1  = 3'd2;
    localparam logic [2:0] CODE_GAP    = 3'd3;
    localparam logic [2:0] CODE_PASS2  = 3'd4;
    localparam logic [2:0] CODE_SEARCH = 3'd5;

    typedef enum logic [5:0] {
        MODE_FOLLOW = 6'b000001,
        MODE_STOP   = 6'b000010,
        MODE_PASS1  = 6'b000100,
        MODE_GAP    = 6'b001000,
        MODE_PASS2  = 6'b010000,
        MODE_SEARCH = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [15:0] new_distance;
        logic        pass_done;
        logic [3:0]  line_bits;
    } tick_word_t;

    typedef struct packed {
        logic        ping_request;
        logic        advance_pass;
        logic [2:0]  drive_command;
        logic [1:0]  start_pass;
        logic        reset_follower;
        logic [2:0]  mode_code;
        logic [15:0] held_distance;
    } result_word_t;

    typedef struct packed {
        logic [15:0] stop_distance;
        logic [15:0] warn_distance;
        logic [15:0] stop_hold_ticks;
        logic [15:0] gap_ticks;
        logic [15:0] search_timeout_ticks;
        logic [15:0] ping_period_ticks;
    } cfg_t;

    function automatic logic [2:0] mode_to_code(input mode_t m);
        logic [2:0] c;
        c = CODE_FOLLOW;
        unique case (m)
            MODE_FOLLOW: c = CODE_FOLLOW;
            MODE_STOP:   c = CODE_STOP;
            MODE_PASS1:  c = CODE_PASS1;
            MODE_GAP:    c = CODE_GAP;
            MODE_PASS2:  c = CODE_PASS2;
            MODE_SEARCH: c = CODE_SEARCH;
            default:     c = CODE_FOLLOW;
        endcase
        return c;
    endfunction

endpackage

### src/oas_cfg_regs.sv
// configuration register file with reset values
module oas_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [oas_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [15:0]                       cfg_data,
    output oas_pkg::cfg_t                     cfg
);

    oas_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_distance        <= 16'd200;
            cfg_reg.warn_distance        <= 16'd400;
            cfg_reg.stop_hold_ticks      <= 16'd500;
            cfg_reg.gap_ticks            <= 16'd2000;
            cfg_reg.search_timeout_ticks <= 16'd3000;
            cfg_reg.ping_period_ticks    <= 16'd60;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                oas_pkg::CFG_STOP_DISTANCE: cfg_reg.stop_distance        <= cfg_data;
                oas_pkg::CFG_WARN_DISTANCE: cfg_reg.warn_distance        <= cfg_data;
                oas_pkg::CFG_STOP_HOLD:     cfg_reg.stop_hold_ticks      <= cfg_data;
                oas_pkg::CFG_GAP:           cfg_reg.gap_ticks            <= cfg_data;
                oas_pkg::CFG_SEARCH_TMO:    cfg_reg.search_timeout_ticks <= cfg_data;
                oas_pkg::CFG_PING_PERIOD:   cfg_reg.ping_period_ticks    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/oas_core.sv
// sequencer state and per-tick next-state and result logic
module oas_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  oas_pkg::tick_word_t   word,
    input  oas_pkg::cfg_t         cfg,
    output oas_pkg::result_word_t result
);

    localparam int TB = oas_pkg::TIMER_BITS;
    localparam int CB = oas_pkg::CMP_BITS;

    oas_pkg::mode_t mode_reg, mode_next;
    logic [TB-1:0]  timer_reg, timer_next;
    logic [15:0]    dist_reg, dist_next;
    logic [15:0]    ping_cnt_reg, ping_cnt_next;

    logic [15:0]    ping_inc;
    logic           ping;
    logic [TB-1:0]  timer_inc;
    logic [CB-1:0]  timer_cmp;
    logic           line_seen;
    logic [2:0]     drive;
    logic [1:0]     start;
    logic           rst_follow;

    always_comb
    begin
        ping_inc = ping_cnt_reg + 16'd1;
        ping     = (ping_inc >= cfg.ping_period_ticks);
        ping_cnt_next = ping ? 16'd0 : ping_inc;

        dist_next = (word.new_distance != 16'd0) ? word.new_distance : dist_reg;

        // saturating phase timer
        timer_inc = (timer_reg == {TB{1'b1}}) ? timer_reg : timer_reg + TB'(1);
        timer_cmp = CB'(timer_inc);
        line_seen = (word.line_bits != oas_pkg::LINE_NONE);

        mode_next  = mode_reg;
        timer_next = timer_inc;
        drive      = oas_pkg::DRIVE_HOLD;
        start      = oas_pkg::START_NONE;
        rst_follow = 1'b0;

        unique case (mode_reg)
            oas_pkg::MODE_STOP:
            begin
                if (timer_cmp >= CB'(cfg.stop_hold_ticks))
                begin
                    start      = oas_pkg::START_PASS1;
                    mode_next  = oas_pkg::MODE_PASS1;
                    timer_next = '0;
                end
            end
            oas_pkg::MODE_PASS1:
            begin
                if (word.pass_done)
                begin
                    drive      = oas_pkg::DRIVE_FORWARD;
                    mode_next  = oas_pkg::MODE_GAP;
                    timer_next = '0;
                end
            end
            oas_pkg::MODE_GAP:
            begin
                if (timer_cmp >= CB'(cfg.gap_ticks))
                begin
                    start      = oas_pkg::START_PASS2;
                    mode_next  = oas_pkg::MODE_PASS2;
                    timer_next = '0;
                end
            end
            oas_pkg::MODE_PASS2:
            begin
                if (word.pass_done)
                begin
                    if (line_seen)
                    begin
                        rst_follow = 1'b1;
                        mode_next  = oas_pkg::MODE_FOLLOW;
                    end
                    else
                    begin
                        drive     = oas_pkg::DRIVE_ROTATE;
                        mode_next = oas_pkg::MODE_SEARCH;
                    end
                    timer_next = '0;
                end
            end
            oas_pkg::MODE_SEARCH:
            begin
                if (line_seen || timer_cmp >= CB'(cfg.search_timeout_ticks))
                begin
                    drive      = oas_pkg::DRIVE_STOP;
                    rst_follow = 1'b1;
                    mode_next  = oas_pkg::MODE_FOLLOW;
                    timer_next = '0;
                end
            end
            default:
            begin
                mode_next = oas_pkg::MODE_FOLLOW;
                if (dist_next != 16'd0 && dist_next <= cfg.stop_distance)
                begin
                    drive      = oas_pkg::DRIVE_STOP;
                    mode_next  = oas_pkg::MODE_STOP;
                    timer_next = '0;
                end
                else if (dist_next != 16'd0 && dist_next <= cfg.warn_distance)
                    drive = oas_pkg::DRIVE_SLOW;
                else
                    drive = oas_pkg::DRIVE_BASE;
            end
        endcase

        result.ping_request   = ping;
        result.advance_pass   = (mode_reg == oas_pkg::MODE_PASS1) ||
                                (mode_reg == oas_pkg::MODE_PASS2);
        result.drive_command  = drive;
        result.start_pass     = start;
        result.reset_follower = rst_follow;
        result.mode_code      = oas_pkg::mode_to_code(mode_next);
        result.held_distance  = dist_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= oas_pkg::MODE_FOLLOW;
            timer_reg    <= '0;
            dist_reg     <= oas_pkg::DIST_RESET;
            ping_cnt_reg <= 16'd0;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            timer_reg    <= timer_next;
            dist_reg     <= dist_next;
            ping_cnt_reg <= ping_cnt_next;
        end
    end

endmodule

### src/obstacle_avoid_sequencer.sv
// obstacle avoidance sequencer top level: tick input, result output, config port
// usage:
//   tick channel: one word per millisecond tick (distance, pass_done, line bits),
//   taken at a clock edge with tick_valid high and tick_stall low
//   result channel: one word per tick (drive command, strobes, mode, held
//   distance), taken at a clock edge with result_valid high and result_stall low
//   config port: cfg_write, cfg_index, cfg_data write one register per edge; user
//   must write only while no tick is in flight (unchecked); unknown indexes ignored
//   path: a taken tick waits in the input register, then the step logic writes
//   its result word into the result register, which drives result_valid
//   throughput: one tick per cycle while result_stall is low; the mode, timer,
//   ping counter and held distance are all updated at each step
//   stall: while result_stall holds a word, the input register keeps one more
//   tick and tick_stall rises only when both registers are full
//   reset: registers return to their reset values, mode is follow, held
//   distance 9999, timers cleared, both registers empty
module obstacle_avoid_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              tick_valid,
    output logic                              tick_stall,
    input  oas_pkg::tick_word_t               tick,
    output logic                              result_valid,
    input  logic                              result_stall,
    output oas_pkg::result_word_t             result,
    input  logic                              cfg_write,
    input  logic [oas_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [15:0]                       cfg_data
);

    oas_pkg::cfg_t         cfg;
    oas_pkg::result_word_t core_result;

    logic                  in_valid_reg;
    oas_pkg::tick_word_t   in_word_reg;
    logic                  out_valid_reg;
    oas_pkg::result_word_t out_word_reg;
    logic                  advance;
    logic                  accept_in;

    // input word moves on when the result register is empty or being taken
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign tick_stall = in_valid_reg && !advance;
    assign accept_in  = tick_valid && !tick_stall;

    oas_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    oas_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .word   (in_word_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
            in_word_reg <= tick;
        if (advance)
            out_word_reg <= core_result;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

endmodule
